FILE: design/nnls_pkg.sv
// ----------------------------------------------------------------------------
// nnls_pkg
// Shared types, widths and constants for the letterbox scaler.
// ----------------------------------------------------------------------------
package nnls_pkg;

  localparam int MAX_SIDE  = 4096;
  localparam int MAX_SCALE = 8;
  localparam int FRAC_BITS = 16;

  localparam int COORD_W = $clog2(MAX_SIDE);
  localparam int SIZE_W  = COORD_W + 1;
  localparam int OFF_W   = COORD_W;
  localparam int COMP_W  = 16;
  localparam int CHAN_W  = 8;
  localparam int COLOR_W = 3 * CHAN_W;
  localparam int ADDR_W  = 24;

  localparam int SCALE_W = FRAC_BITS + $clog2(MAX_SCALE) + 1;
  localparam int QUOT_W  = SIZE_W + FRAC_BITS;
  localparam int DCNT_W  = $clog2(QUOT_W);
  localparam int PROD_W  = SIZE_W + SCALE_W;
  localparam int PIX_W   = PROD_W - FRAC_BITS;
  localparam int EXT_W   = PIX_W + 1;
  localparam int CNT_W   = $clog2(MAX_SCALE + 1);
  localparam int BASE_W  = 2 * SIZE_W;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [SCALE_W-1:0] SCALE_LIMIT = SCALE_W'(MAX_SCALE) << FRAC_BITS;
  localparam logic [CHAN_W-1:0]  CHAN_MAX    = '1;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_HEIGHT   = 3'd3;

  localparam logic [SIZE_W-1:0] RST_SOURCE_WIDTH  = 13'd320;
  localparam logic [SIZE_W-1:0] RST_SOURCE_HEIGHT = 13'd240;
  localparam logic [SIZE_W-1:0] RST_DEST_WIDTH    = 13'd640;
  localparam logic [SIZE_W-1:0] RST_DEST_HEIGHT   = 13'd480;

  typedef struct packed {
    logic        [COORD_W-1:0] src_x;
    logic        [COORD_W-1:0] src_y;
    logic signed [COMP_W-1:0]  red_in;
    logic signed [COMP_W-1:0]  green_in;
    logic signed [COMP_W-1:0]  blue_in;
  } src_pixel_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  dest_addr;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_write;
  } fb_write_t;

  // geometry derived from the size registers; sizes already forced nonzero
  typedef struct packed {
    logic               busy;
    logic [SCALE_W-1:0] scale;
    logic [OFF_W-1:0]   offset_x;
    logic [OFF_W-1:0]   offset_y;
    logic [SIZE_W-1:0]  src_w;
    logic [SIZE_W-1:0]  src_h;
    logic [SIZE_W-1:0]  dst_w;
    logic [SIZE_W-1:0]  dst_h;
  } geom_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [CNT_W-1:0]   nrows;
    logic [CNT_W-1:0]   ncols;
    logic [COLOR_W-1:0] color;
  } fp_job_t;

  typedef enum logic [2:0] {
    SET_IDLE,
    SET_DIV_X,
    SET_DIV_Y,
    SET_MUL_W,
    SET_MUL_H,
    SET_OFF_Y
  } setup_state_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_BOUND,
    F_PUSH
  } front_state_t;

endpackage

FILE: design/nnls_setup.sv
// ----------------------------------------------------------------------------
// nnls_setup
// Size registers and the sequencer that derives scale and letterbox offsets.
// ----------------------------------------------------------------------------
module nnls_setup (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [nnls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nnls_pkg::SIZE_W-1:0]     cfg_data,
  output nnls_pkg::geom_t                 geom
);

  nnls_pkg::setup_state_t state, state_next;

  logic [nnls_pkg::SIZE_W-1:0]  src_w, src_h, dst_w, dst_h;
  logic [nnls_pkg::SIZE_W-1:0]  sw_nz, sh_nz, dw_nz, dh_nz;
  logic [nnls_pkg::DCNT_W-1:0]  cnt;
  logic [nnls_pkg::SIZE_W-1:0]  rem, rem_next;
  logic [nnls_pkg::QUOT_W-1:0]  quo, quo_next, quo_x;
  logic [nnls_pkg::SCALE_W-1:0] scale;
  logic [nnls_pkg::OFF_W-1:0]   offset_x, offset_y;
  logic [nnls_pkg::PROD_W-1:0]  prod;

  logic                         cfg_hit;
  logic [nnls_pkg::QUOT_W-1:0]  dividend;
  logic [nnls_pkg::SIZE_W-1:0]  divisor;
  logic [nnls_pkg::SIZE_W:0]    trial;
  logic                         ge;
  logic [nnls_pkg::QUOT_W-1:0]  quo_min;
  logic [nnls_pkg::SCALE_W-1:0] scale_next;
  logic [nnls_pkg::SIZE_W-1:0]  mul_side;
  logic [nnls_pkg::SIZE_W-1:0]  off_dst;
  logic [nnls_pkg::OFF_W-1:0]   off_val;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index <= nnls_pkg::CFG_DEST_HEIGHT);

  assign sw_nz = (src_w == '0) ? nnls_pkg::SIZE_W'(1) : src_w;
  assign sh_nz = (src_h == '0) ? nnls_pkg::SIZE_W'(1) : src_h;
  assign dw_nz = (dst_w == '0) ? nnls_pkg::SIZE_W'(1) : dst_w;
  assign dh_nz = (dst_h == '0) ? nnls_pkg::SIZE_W'(1) : dst_h;

  // restoring divider, one quotient bit per cycle
  always_comb begin
    if (state == nnls_pkg::SET_DIV_Y) begin
      dividend = {dh_nz, nnls_pkg::FRAC_BITS'(0)};
      divisor  = sh_nz;
    end else begin
      dividend = {dw_nz, nnls_pkg::FRAC_BITS'(0)};
      divisor  = sw_nz;
    end
    trial    = {rem, dividend[cnt]};
    ge       = trial >= {1'b0, divisor};
    rem_next = ge ? nnls_pkg::SIZE_W'(trial - {1'b0, divisor})
                  : trial[nnls_pkg::SIZE_W-1:0];
    quo_next = {quo[nnls_pkg::QUOT_W-2:0], ge};
    quo_min  = (quo_x < quo_next) ? quo_x : quo_next;
    scale_next = (quo_min > nnls_pkg::QUOT_W'(nnls_pkg::SCALE_LIMIT))
                 ? nnls_pkg::SCALE_LIMIT : quo_min[nnls_pkg::SCALE_W-1:0];
  end

  // offset = (dst - round_half_up(side * scale)) / 2, or 0 when it overflows
  always_comb begin
    logic [nnls_pkg::PROD_W:0]    rounded;
    logic [nnls_pkg::EXT_W-1:0]   out_sz;
    logic [nnls_pkg::SIZE_W-1:0]  diff;
    rounded = {1'b0, prod} + ((nnls_pkg::PROD_W + 1)'(1) << (nnls_pkg::FRAC_BITS - 1));
    out_sz  = rounded[nnls_pkg::FRAC_BITS +: nnls_pkg::EXT_W];
    off_dst = (state == nnls_pkg::SET_OFF_Y) ? dh_nz : dw_nz;
    diff    = nnls_pkg::SIZE_W'(nnls_pkg::EXT_W'(off_dst) - out_sz);
    off_val = (out_sz <= nnls_pkg::EXT_W'(off_dst)) ? diff[nnls_pkg::SIZE_W-1:1] : '0;
    mul_side = (state == nnls_pkg::SET_MUL_W) ? sw_nz : sh_nz;
  end

  always_comb begin
    state_next = state;
    case (state)
      nnls_pkg::SET_IDLE:  state_next = nnls_pkg::SET_IDLE;
      nnls_pkg::SET_DIV_X: if (cnt == '0) state_next = nnls_pkg::SET_DIV_Y;
      nnls_pkg::SET_DIV_Y: if (cnt == '0) state_next = nnls_pkg::SET_MUL_W;
      nnls_pkg::SET_MUL_W: state_next = nnls_pkg::SET_MUL_H;
      nnls_pkg::SET_MUL_H: state_next = nnls_pkg::SET_OFF_Y;
      nnls_pkg::SET_OFF_Y: state_next = nnls_pkg::SET_IDLE;
      default:             state_next = nnls_pkg::SET_IDLE;
    endcase
    if (cfg_hit) state_next = nnls_pkg::SET_DIV_X;
  end

  always_comb begin
    geom.busy     = (state != nnls_pkg::SET_IDLE);
    geom.scale    = scale;
    geom.offset_x = offset_x;
    geom.offset_y = offset_y;
    geom.src_w    = sw_nz;
    geom.src_h    = sh_nz;
    geom.dst_w    = dw_nz;
    geom.dst_h    = dh_nz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nnls_pkg::SET_DIV_X;
      src_w <= nnls_pkg::RST_SOURCE_WIDTH;
      src_h <= nnls_pkg::RST_SOURCE_HEIGHT;
      dst_w <= nnls_pkg::RST_DEST_WIDTH;
      dst_h <= nnls_pkg::RST_DEST_HEIGHT;
      cnt   <= nnls_pkg::DCNT_W'(nnls_pkg::QUOT_W - 1);
      rem   <= '0;
    end else begin
      state <= state_next;
      if (cfg_hit) begin
        cnt <= nnls_pkg::DCNT_W'(nnls_pkg::QUOT_W - 1);
        rem <= '0;
        case (cfg_index)
          nnls_pkg::CFG_SOURCE_WIDTH:  src_w <= cfg_data;
          nnls_pkg::CFG_SOURCE_HEIGHT: src_h <= cfg_data;
          nnls_pkg::CFG_DEST_WIDTH:    dst_w <= cfg_data;
          nnls_pkg::CFG_DEST_HEIGHT:   dst_h <= cfg_data;
          default: ;
        endcase
      end else begin
        case (state)
          nnls_pkg::SET_DIV_X, nnls_pkg::SET_DIV_Y: begin
            quo <= quo_next;
            if (cnt == '0) begin
              cnt <= nnls_pkg::DCNT_W'(nnls_pkg::QUOT_W - 1);
              rem <= '0;
              if (state == nnls_pkg::SET_DIV_X) quo_x <= quo_next;
              else scale <= scale_next;
            end else begin
              cnt <= cnt - 1'b1;
              rem <= rem_next;
            end
          end
          nnls_pkg::SET_MUL_W: prod <= nnls_pkg::PROD_W'(mul_side) * nnls_pkg::PROD_W'(scale);
          nnls_pkg::SET_MUL_H: begin
            offset_x <= off_val;
            prod     <= nnls_pkg::PROD_W'(mul_side) * nnls_pkg::PROD_W'(scale);
          end
          nnls_pkg::SET_OFF_Y: offset_y <= off_val;
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: design/nnls_front.sv
// ----------------------------------------------------------------------------
// nnls_front
// Accepts pixels, clamps color and maps each to a footprint job or drops it.
// ----------------------------------------------------------------------------
module nnls_front (
  input  logic                 clk,
  input  logic                 rst,
  input  nnls_pkg::geom_t      geom,
  input  logic                 src_valid,
  output logic                 src_ready,
  input  nnls_pkg::src_pixel_t src_pixel,
  output logic                 job_valid,
  input  logic                 job_ready,
  output nnls_pkg::fp_job_t    job
);

  nnls_pkg::front_state_t state, state_next;

  logic [nnls_pkg::COORD_W-1:0] x_q, y_q;
  logic [nnls_pkg::COLOR_W-1:0] color_q;
  logic                         step;
  logic [nnls_pkg::PIX_W-1:0]   py0, py1, px0, px1;
  logic [nnls_pkg::SIZE_W-1:0]  row0, col0;
  logic [nnls_pkg::CNT_W-1:0]   nrows, ncols;

  logic [nnls_pkg::SIZE_W-1:0]  op_x, op_y;
  logic [nnls_pkg::PROD_W-1:0]  prod_x, prod_y;
  logic [nnls_pkg::COLOR_W-1:0] color_in;
  logic                         drop;
  logic [nnls_pkg::EXT_W-1:0]   y0, y1, x0, x1;
  logic [nnls_pkg::BASE_W-1:0]  base;

  function automatic logic [nnls_pkg::CHAN_W-1:0] clamp(
    input logic signed [nnls_pkg::COMP_W-1:0] v
  );
    if (v < 0) return '0;
    if (v > $signed(nnls_pkg::COMP_W'(nnls_pkg::CHAN_MAX))) return nnls_pkg::CHAN_MAX;
    return v[nnls_pkg::CHAN_W-1:0];
  endfunction

  // end of a footprint on one axis: at least one pixel, clipped to the frame
  function automatic logic [nnls_pkg::EXT_W-1:0] span_end(
    input logic [nnls_pkg::EXT_W-1:0]  lo,
    input logic [nnls_pkg::EXT_W-1:0]  hi,
    input logic [nnls_pkg::SIZE_W-1:0] lim
  );
    logic [nnls_pkg::EXT_W-1:0] h;
    h = (hi <= lo) ? lo + 1'b1 : hi;
    return (h > nnls_pkg::EXT_W'(lim)) ? nnls_pkg::EXT_W'(lim) : h;
  endfunction

  assign color_in = {clamp(src_pixel.red_in), clamp(src_pixel.green_in),
                     clamp(src_pixel.blue_in)};

  assign op_x   = nnls_pkg::SIZE_W'(x_q) + nnls_pkg::SIZE_W'(step);
  assign op_y   = nnls_pkg::SIZE_W'(y_q) + nnls_pkg::SIZE_W'(step);
  assign prod_x = nnls_pkg::PROD_W'(op_x) * nnls_pkg::PROD_W'(geom.scale);
  assign prod_y = nnls_pkg::PROD_W'(op_y) * nnls_pkg::PROD_W'(geom.scale);

  always_comb begin
    y0 = nnls_pkg::EXT_W'(geom.offset_y) + nnls_pkg::EXT_W'(py0);
    x0 = nnls_pkg::EXT_W'(geom.offset_x) + nnls_pkg::EXT_W'(px0);
    y1 = span_end(y0, nnls_pkg::EXT_W'(geom.offset_y) + nnls_pkg::EXT_W'(py1), geom.dst_h);
    x1 = span_end(x0, nnls_pkg::EXT_W'(geom.offset_x) + nnls_pkg::EXT_W'(px1), geom.dst_w);
    drop = (nnls_pkg::SIZE_W'(x_q) >= geom.src_w) || (nnls_pkg::SIZE_W'(y_q) >= geom.src_h)
        || (y0 >= y1) || (x0 >= x1);
  end

  assign base = nnls_pkg::BASE_W'(row0) * nnls_pkg::BASE_W'(geom.dst_w)
              + nnls_pkg::BASE_W'(col0);

  always_comb begin
    state_next = state;
    case (state)
      nnls_pkg::F_IDLE:  if (src_valid && src_ready) state_next = nnls_pkg::F_MUL;
      nnls_pkg::F_MUL:   if (step) state_next = nnls_pkg::F_BOUND;
      nnls_pkg::F_BOUND: state_next = drop ? nnls_pkg::F_IDLE : nnls_pkg::F_PUSH;
      nnls_pkg::F_PUSH:  if (job_ready) state_next = nnls_pkg::F_IDLE;
      default:           state_next = nnls_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    src_ready = (state == nnls_pkg::F_IDLE) && !geom.busy;
    job_valid = (state == nnls_pkg::F_PUSH);
    job.base  = base[nnls_pkg::ADDR_W-1:0];
    job.nrows = nrows;
    job.ncols = ncols;
    job.color = color_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nnls_pkg::F_IDLE;
      step  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        nnls_pkg::F_IDLE: begin
          step <= 1'b0;
          if (src_valid && src_ready) begin
            x_q     <= src_pixel.src_x;
            y_q     <= src_pixel.src_y;
            color_q <= color_in;
          end
        end
        nnls_pkg::F_MUL: begin
          step <= 1'b1;
          if (step) begin
            py1 <= prod_y[nnls_pkg::FRAC_BITS +: nnls_pkg::PIX_W];
            px1 <= prod_x[nnls_pkg::FRAC_BITS +: nnls_pkg::PIX_W];
          end else begin
            py0 <= prod_y[nnls_pkg::FRAC_BITS +: nnls_pkg::PIX_W];
            px0 <= prod_x[nnls_pkg::FRAC_BITS +: nnls_pkg::PIX_W];
          end
        end
        nnls_pkg::F_BOUND: begin
          // fields only meaningful when the footprint survives
          row0  <= y0[nnls_pkg::SIZE_W-1:0];
          col0  <= x0[nnls_pkg::SIZE_W-1:0];
          nrows <= nnls_pkg::CNT_W'(y1 - y0);
          ncols <= nnls_pkg::CNT_W'(x1 - x0);
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: design/nnls_queue.sv
// ----------------------------------------------------------------------------
// nnls_queue
// Short job queue between the front and the write engine.
// ----------------------------------------------------------------------------
module nnls_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  nnls_pkg::fp_job_t push_job,
  output logic              pop_valid,
  input  logic              pop_ready,
  output nnls_pkg::fp_job_t pop_job
);

  nnls_pkg::fp_job_t           slots [nnls_pkg::QDEPTH];
  logic [nnls_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [nnls_pkg::QCNT_W-1:0] count;
  logic                        do_push, do_pop;

  assign push_ready = (count != nnls_pkg::QCNT_W'(nnls_pkg::QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [nnls_pkg::QPTR_W-1:0] bump(
    input logic [nnls_pkg::QPTR_W-1:0] p
  );
    return (p == nnls_pkg::QPTR_W'(nnls_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        slots[wr_ptr] <= push_job;
        wr_ptr        <= bump(wr_ptr);
      end
      if (do_pop) rd_ptr <= bump(rd_ptr);
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

FILE: design/nnls_back.sv
// ----------------------------------------------------------------------------
// nnls_back
// Walks each footprint row by row and issues frame-buffer writes.
// ----------------------------------------------------------------------------
module nnls_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [nnls_pkg::SIZE_W-1:0] dst_w,
  input  logic                        job_valid,
  output logic                        job_ready,
  input  nnls_pkg::fp_job_t           job,
  output logic                        fb_valid,
  input  logic                        fb_ready,
  output nnls_pkg::fb_write_t         fb_write
);

  logic                         busy;
  logic [nnls_pkg::ADDR_W-1:0]  row_base;
  logic [nnls_pkg::CNT_W-1:0]   footprint_row, footprint_col;
  logic [nnls_pkg::CNT_W-1:0]   nrows, ncols;
  logic [nnls_pkg::COLOR_W-1:0] color;

  logic advance, col_end, last;

  assign advance   = busy && (!fb_valid || fb_ready);
  assign col_end   = (footprint_col == ncols - 1'b1);
  assign last      = col_end && (footprint_row == nrows - 1'b1);
  assign job_ready = !busy || (advance && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      fb_valid      <= 1'b0;
      footprint_row <= '0;
      footprint_col <= '0;
    end else begin
      fb_valid <= advance || (fb_valid && !fb_ready);
      if (advance) begin
        fb_write.dest_addr   <= row_base + nnls_pkg::ADDR_W'(footprint_col);
        fb_write.pixel_color <= color;
        fb_write.last_write  <= last;
      end
      if (job_valid && job_ready) begin
        busy          <= 1'b1;
        row_base      <= job.base;
        nrows         <= job.nrows;
        ncols         <= job.ncols;
        color         <= job.color;
        footprint_row <= '0;
        footprint_col <= '0;
      end else if (advance) begin
        if (last) begin
          busy          <= 1'b0;
          footprint_row <= '0;
          footprint_col <= '0;
        end else if (col_end) begin
          footprint_col <= '0;
          footprint_row <= footprint_row + 1'b1;
          row_base      <= row_base + nnls_pkg::ADDR_W'(dst_w);
        end else begin
          footprint_col <= footprint_col + 1'b1;
        end
      end
    end
  end

endmodule

FILE: design/nearest_neighbor_letterbox_scaler.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_letterbox_scaler
// Maps source pixels onto a letterboxed destination frame, nearest neighbor.
// ----------------------------------------------------------------------------
//  channel   signals                                    direction  payload
//  src       src_valid src_ready src_pixel              in         src_pixel_t
//  fb        fb_valid fb_ready fb_write                 out        fb_write_t
//  cfg       cfg_valid cfg_ready cfg_index cfg_data     in         13-bit size
//
//  Front: accept, two multiply steps, bounds, and a queue push unless dropped;
//  no new pixel is taken until the last is done. Back: one write per cycle
//  while fb_ready does not stall it, rows x cols writes per pixel; a
//  two-entry queue sits between them. After reset or a size register write,
//  the sequencer runs the X and Y divisions, then multiply/offset steps, with
//  src_ready low. Either side may stall; the job queue decouples the two.
// ----------------------------------------------------------------------------
module nearest_neighbor_letterbox_scaler (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            src_valid,
  output logic                            src_ready,
  input  nnls_pkg::src_pixel_t            src_pixel,
  output logic                            fb_valid,
  input  logic                            fb_ready,
  output nnls_pkg::fb_write_t             fb_write,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [nnls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nnls_pkg::SIZE_W-1:0]     cfg_data
);

  nnls_pkg::geom_t   geom;
  nnls_pkg::fp_job_t job_in, job_out;
  logic              job_in_valid, job_in_ready;
  logic              job_out_valid, job_out_ready;

  nnls_setup u_setup (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  nnls_front u_front (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_pixel (src_pixel),
    .job_valid (job_in_valid),
    .job_ready (job_in_ready),
    .job       (job_in)
  );

  nnls_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (job_in_valid),
    .push_ready (job_in_ready),
    .push_job   (job_in),
    .pop_valid  (job_out_valid),
    .pop_ready  (job_out_ready),
    .pop_job    (job_out)
  );

  nnls_back u_back (
    .clk       (clk),
    .rst       (rst),
    .dst_w     (geom.dst_w),
    .job_valid (job_out_valid),
    .job_ready (job_out_ready),
    .job       (job_out),
    .fb_valid  (fb_valid),
    .fb_ready  (fb_ready),
    .fb_write  (fb_write)
  );

  // no pixel is taken while the geometry is being rebuilt
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    src_ready |-> !geom.busy)
    else $error("pixel accepted during geometry update");

  a_cfg_restarts: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && (cfg_index <= nnls_pkg::CFG_DEST_HEIGHT) |=> geom.busy)
    else $error("size write did not restart geometry");

  a_scale_range: assert property (@(posedge clk) disable iff (rst)
    !geom.busy |-> (geom.scale != '0) && (geom.scale <= nnls_pkg::SCALE_LIMIT))
    else $error("scale out of range");

  a_job_size: assert property (@(posedge clk) disable iff (rst)
    job_in_valid |-> (job_in.nrows != '0) && (job_in.ncols != '0)
      && (job_in.nrows <= nnls_pkg::CNT_W'(nnls_pkg::MAX_SCALE))
      && (job_in.ncols <= nnls_pkg::CNT_W'(nnls_pkg::MAX_SCALE)))
    else $error("footprint size out of range");

endmodule

FILE: sim/nearest_neighbor_letterbox_scaler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_neighbor_letterbox_scaler_tb
// Drives source pixels and size registers into the letterbox scaler, predicts
// every frame-buffer write in order and checks each write field by field.
// ----------------------------------------------------------------------------
module nearest_neighbor_letterbox_scaler_tb;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 2;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASE_ITEMS   = 54;
  localparam int PHASE_COUNT   = 8;
  localparam int FLOOD_ITEMS   = 20;
  localparam logic [nnls_pkg::CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd5;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           src_valid = 1'b0;
  logic                           src_ready;
  nnls_pkg::src_pixel_t           src_pixel = '0;
  logic                           fb_valid;
  logic                           fb_ready = 1'b0;
  nnls_pkg::fb_write_t            fb_write;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [nnls_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [nnls_pkg::SIZE_W-1:0]    cfg_data = '0;

  nearest_neighbor_letterbox_scaler dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_pixel (src_pixel),
    .fb_valid  (fb_valid),
    .fb_ready  (fb_ready),
    .fb_write  (fb_write),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // predictor copy of the size registers and derived geometry
  logic [nnls_pkg::SIZE_W-1:0] size_src_w = nnls_pkg::RST_SOURCE_WIDTH;
  logic [nnls_pkg::SIZE_W-1:0] size_src_h = nnls_pkg::RST_SOURCE_HEIGHT;
  logic [nnls_pkg::SIZE_W-1:0] size_dst_w = nnls_pkg::RST_DEST_WIDTH;
  logic [nnls_pkg::SIZE_W-1:0] size_dst_h = nnls_pkg::RST_DEST_HEIGHT;
  longint unsigned             scale_q, lb_off_x, lb_off_y;

  nnls_pkg::fb_write_t pending_writes[$];

  int err_count      = 0;
  int pixels_sent    = 0;
  int writes_checked = 0;
  int settings_used  = 1;
  int src_idle_pct   = 0;
  int fb_stall_pct   = 0;
  int hold_seq       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int cycle_count    = 0;

  function automatic longint unsigned at_least_one(longint unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic void update_geometry();
    longint unsigned sw, sh, dw, dh, sx, sy, s, lim, ow, oh;
    sw  = at_least_one(size_src_w);
    sh  = at_least_one(size_src_h);
    dw  = at_least_one(size_dst_w);
    dh  = at_least_one(size_dst_h);
    sx  = (dw << nnls_pkg::FRAC_BITS) / sw;
    sy  = (dh << nnls_pkg::FRAC_BITS) / sh;
    s   = (sx < sy) ? sx : sy;
    lim = longint'(nnls_pkg::MAX_SCALE) << nnls_pkg::FRAC_BITS;
    if (s > lim) s = lim;
    // scaled image size, rounded half-up
    ow = (sw * s + (64'd1 << (nnls_pkg::FRAC_BITS - 1))) >> nnls_pkg::FRAC_BITS;
    oh = (sh * s + (64'd1 << (nnls_pkg::FRAC_BITS - 1))) >> nnls_pkg::FRAC_BITS;
    scale_q  = s;
    lb_off_x = (ow <= dw) ? (dw - ow) / 2 : 0;
    lb_off_y = (oh <= dh) ? (dh - oh) / 2 : 0;
  endfunction

  function automatic logic [nnls_pkg::CHAN_W-1:0] clamp_channel(
    logic signed [nnls_pkg::COMP_W-1:0] v
  );
    if (v < 0) return '0;
    if (v > 255) return nnls_pkg::CHAN_MAX;
    return v[nnls_pkg::CHAN_W-1:0];
  endfunction

  // queue the footprint writes of one accepted pixel, rows first
  function automatic void predict_fb_writes(nnls_pkg::src_pixel_t p);
    longint unsigned x, y, dw, dh, x0, x1, y0, y1, r, c;
    logic [nnls_pkg::COLOR_W-1:0] color;
    nnls_pkg::fb_write_t w;
    x  = p.src_x;
    y  = p.src_y;
    dw = at_least_one(size_dst_w);
    dh = at_least_one(size_dst_h);
    if (x >= at_least_one(size_src_w) || y >= at_least_one(size_src_h)) return;
    color = {clamp_channel(p.red_in), clamp_channel(p.green_in), clamp_channel(p.blue_in)};
    y0 = lb_off_y + ((y * scale_q) >> nnls_pkg::FRAC_BITS);
    y1 = lb_off_y + (((y + 1) * scale_q) >> nnls_pkg::FRAC_BITS);
    if (y1 <= y0) y1 = y0 + 1;
    x0 = lb_off_x + ((x * scale_q) >> nnls_pkg::FRAC_BITS);
    x1 = lb_off_x + (((x + 1) * scale_q) >> nnls_pkg::FRAC_BITS);
    if (x1 <= x0) x1 = x0 + 1;
    if (y1 > dh) y1 = dh;
    if (x1 > dw) x1 = dw;
    for (r = y0; r < y1; r++) begin
      for (c = x0; c < x1; c++) begin
        w.dest_addr   = nnls_pkg::ADDR_W'(r * dw + c);
        w.pixel_color = color;
        w.last_write  = (r == y1 - 1) && (c == x1 - 1);
        pending_writes.push_back(w);
      end
    end
  endfunction

  function automatic nnls_pkg::src_pixel_t make_pixel(
    logic [nnls_pkg::COORD_W-1:0] x,
    logic [nnls_pkg::COORD_W-1:0] y,
    logic signed [nnls_pkg::COMP_W-1:0] r,
    logic signed [nnls_pkg::COMP_W-1:0] g,
    logic signed [nnls_pkg::COMP_W-1:0] b
  );
    nnls_pkg::src_pixel_t p;
    p.src_x    = x;
    p.src_y    = y;
    p.red_in   = r;
    p.green_in = g;
    p.blue_in  = b;
    return p;
  endfunction

  function automatic logic signed [nnls_pkg::COMP_W-1:0] random_component();
    case ($urandom_range(2))
      0:       return nnls_pkg::COMP_W'($urandom);
      // around the clamp edges
      1:       return nnls_pkg::COMP_W'($urandom_range(316)) - 16'd16;
      default: return nnls_pkg::COMP_W'($urandom_range(255));
    endcase
  endfunction

  // mostly pixels inside the source image, some anywhere in the coordinate range
  function automatic nnls_pkg::src_pixel_t random_pixel();
    longint unsigned w_lim, h_lim;
    logic [nnls_pkg::COORD_W-1:0] x, y;
    w_lim = at_least_one(size_src_w);
    h_lim = at_least_one(size_src_h);
    if (w_lim > nnls_pkg::MAX_SIDE) w_lim = nnls_pkg::MAX_SIDE;
    if (h_lim > nnls_pkg::MAX_SIDE) h_lim = nnls_pkg::MAX_SIDE;
    if ($urandom_range(99) < 12) begin
      x = nnls_pkg::COORD_W'($urandom_range(nnls_pkg::MAX_SIDE - 1));
      y = nnls_pkg::COORD_W'($urandom_range(nnls_pkg::MAX_SIDE - 1));
    end else begin
      x = nnls_pkg::COORD_W'($urandom_range(32'(w_lim - 1)));
      y = nnls_pkg::COORD_W'($urandom_range(32'(h_lim - 1)));
    end
    return make_pixel(x, y, random_component(), random_component(), random_component());
  endfunction

  task automatic set_idling(input int src_pct, input int fb_pct);
    src_idle_pct = src_pct;
    fb_stall_pct = fb_pct;
  endtask

  // sender stops until every predicted write is out and the pipe has settled
  task automatic wait_frame_idle();
    src_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_valid high; program_geometry lowers it after the last write
  task automatic write_size(input logic [nnls_pkg::CFG_IDX_W-1:0] idx,
                            input logic [nnls_pkg::SIZE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      nnls_pkg::CFG_SOURCE_WIDTH:  size_src_w = val;
      nnls_pkg::CFG_SOURCE_HEIGHT: size_src_h = val;
      nnls_pkg::CFG_DEST_WIDTH:    size_dst_w = val;
      nnls_pkg::CFG_DEST_HEIGHT:   size_dst_h = val;
      default: ;
    endcase
    update_geometry();
  endtask

  task automatic program_geometry(input logic [nnls_pkg::SIZE_W-1:0] sw,
                                  input logic [nnls_pkg::SIZE_W-1:0] sh,
                                  input logic [nnls_pkg::SIZE_W-1:0] dw,
                                  input logic [nnls_pkg::SIZE_W-1:0] dh,
                                  input logic poke_unused);
    wait_frame_idle();
    if (poke_unused) write_size(CFG_UNUSED_INDEX, '1);
    write_size(nnls_pkg::CFG_SOURCE_WIDTH, sw);
    write_size(nnls_pkg::CFG_SOURCE_HEIGHT, sh);
    write_size(nnls_pkg::CFG_DEST_WIDTH, dw);
    write_size(nnls_pkg::CFG_DEST_HEIGHT, dh);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic send_pixel(input nnls_pkg::src_pixel_t p);
    if ($urandom_range(99) < src_idle_pct) begin
      src_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_pixel <= p;
    @(posedge clk);
    while (!src_ready) @(posedge clk);
    predict_fb_writes(p);
    pixels_sent++;
  endtask

  // reset geometry (2x, no letterbox): color clamping and pixels off the source
  task automatic test_reset_geometry();
    set_idling(11, 11);
    send_pixel(make_pixel(12'd0, 12'd0, 16'sh7FFF, 16'sh8000, 16'sh0000));
    send_pixel(make_pixel(12'd319, 12'd239, 16'sd255, 16'sd256, -16'sd1));
    send_pixel(make_pixel(12'd160, 12'd120, 16'sh00AA, 16'sh7F00, 16'sh0055));
    send_pixel(make_pixel(12'd320, 12'd0, 16'sd10, 16'sd20, 16'sd30));
    send_pixel(make_pixel(12'd0, 12'd240, 16'sd10, 16'sd20, 16'sd30));
    send_pixel(make_pixel(12'd4095, 12'd4095, 16'shFFFF, 16'sh00FF, 16'sh0100));
  endtask

  // all size registers zero behave as 1x1
  task automatic test_zero_sizes();
    program_geometry('0, '0, '0, '0, 1'b0);
    send_pixel(make_pixel(12'd0, 12'd0, 16'sd1, 16'sd2, 16'sd3));
    send_pixel(make_pixel(12'd1, 12'd0, 16'sd1, 16'sd2, 16'sd3));
    send_pixel(make_pixel(12'd0, 12'd1, 16'sd1, 16'sd2, 16'sd3));
  endtask

  // widest destination: row * width overflows 24 bits for rows past 2048
  task automatic test_wrapped_addresses();
    program_geometry(13'd1024, 13'd1024, '1, '1, 1'b0);
    send_pixel(make_pixel(12'd1023, 12'd1023, 16'sd200, 16'sd100, 16'sd50));
    send_pixel(make_pixel(12'd0, 12'd0, 16'sd7, 16'sd8, 16'sd9));
    send_pixel(make_pixel(12'd512, 12'd1023, -16'sd5, 16'sd300, 16'sd128));
  endtask

  // largest source onto one pixel: footprints forced to a single write
  task automatic test_min_scale();
    program_geometry('1, '1, 13'd1, 13'd1, 1'b1);
    send_pixel(make_pixel(12'd0, 12'd0, 16'sd11, 16'sd22, 16'sd33));
    send_pixel(make_pixel(12'd4095, 12'd4095, 16'sd44, 16'sd55, 16'sd66));
  endtask

  // fractional scale with odd sizes, corners of the image
  task automatic test_edge_rounding();
    program_geometry(13'd3, 13'd5, 13'd10, 13'd7, 1'b0);
    send_pixel(make_pixel(12'd2, 12'd4, 16'sd90, 16'sd91, 16'sd92));
    send_pixel(make_pixel(12'd0, 12'd4, 16'sd93, 16'sd94, 16'sd95));
    send_pixel(make_pixel(12'd2, 12'd0, 16'sd96, 16'sd97, 16'sd98));
  endtask

  // 8x footprints while the output is held off: input must stall, then drain
  task automatic test_backpressure();
    program_geometry(13'd16, 13'd16, 13'd4096, 13'd4096, 1'b0);
    set_idling(0, 0);
    hold_seq <= hold_seq + 1;
    repeat (FLOOD_ITEMS) send_pixel(random_pixel());
    wait_frame_idle();
  endtask

  task automatic test_random_phase(input int phase);
    logic [nnls_pkg::SIZE_W-1:0] sw, sh, dw, dh;
    case (phase % 4)
      0: begin  // small sources, mostly saturated upscale
        sw = nnls_pkg::SIZE_W'($urandom_range(1, 32));
        sh = nnls_pkg::SIZE_W'($urandom_range(1, 32));
        dw = nnls_pkg::SIZE_W'($urandom_range(1, 4096));
        dh = nnls_pkg::SIZE_W'($urandom_range(1, 4096));
      end
      1: begin
        sw = nnls_pkg::SIZE_W'($urandom_range(1, 4096));
        sh = nnls_pkg::SIZE_W'($urandom_range(1, 4096));
        dw = nnls_pkg::SIZE_W'($urandom_range(1, 4096));
        dh = nnls_pkg::SIZE_W'($urandom_range(1, 4096));
      end
      2: begin  // full register range, zero included
        sw = nnls_pkg::SIZE_W'($urandom_range(0, 8191));
        sh = nnls_pkg::SIZE_W'($urandom_range(0, 8191));
        dw = nnls_pkg::SIZE_W'($urandom_range(0, 8191));
        dh = nnls_pkg::SIZE_W'($urandom_range(0, 8191));
      end
      default: begin  // every source coordinate is inside the image
        sw = 13'd4096;
        sh = 13'd4096;
        dw = nnls_pkg::SIZE_W'($urandom_range(1, 4096));
        dh = nnls_pkg::SIZE_W'($urandom_range(1, 4096));
      end
    endcase
    program_geometry(sw, sh, dw, dh, 1'b0);
    case ((phase + phase / 4) % 4)
      0:       set_idling(0, 0);
      1:       set_idling(61, 0);
      2:       set_idling(0, 61);
      default: set_idling(11, 11);
    endcase
    repeat (PHASE_ITEMS) send_pixel(random_pixel());
  endtask

  // output side: random stalls, plus a long hold each time hold_seq moves
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      fb_ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      fb_ready  <= 1'b0;
    end else begin
      fb_ready <= ($urandom_range(99) >= fb_stall_pct);
    end
  end

  always @(posedge clk) begin
    nnls_pkg::fb_write_t want;
    if (!rst && fb_valid && fb_ready) begin
      if (pending_writes.size() == 0) begin
        err_count++;
        $display("%0t: unexpected write: expected none, got addr %h color %h last %b",
                 $time, fb_write.dest_addr, fb_write.pixel_color, fb_write.last_write);
      end else begin
        want = pending_writes.pop_front();
        writes_checked++;
        if (fb_write.dest_addr !== want.dest_addr) begin
          err_count++;
          $display("%0t: dest_addr mismatch: expected %h, got %h",
                   $time, want.dest_addr, fb_write.dest_addr);
        end
        if (fb_write.pixel_color !== want.pixel_color) begin
          err_count++;
          $display("%0t: pixel_color mismatch: expected %h, got %h",
                   $time, want.pixel_color, fb_write.pixel_color);
        end
        if (fb_write.last_write !== want.last_write) begin
          err_count++;
          $display("%0t: last_write mismatch: expected %b, got %b",
                   $time, want.last_write, fb_write.last_write);
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int ph;
    update_geometry();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_reset_geometry();
    test_zero_sizes();
    test_wrapped_addresses();
    test_min_scale();
    test_edge_rounding();
    test_backpressure();
    for (ph = 0; ph < PHASE_COUNT; ph++) test_random_phase(ph);
    wait_frame_idle();
    $display("Covered %0d source pixels over %0d size settings, %0d writes checked,",
             pixels_sent, settings_used, writes_checked);
    $display("with idle and stall mixes on both channels and one long output hold.");
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: sim.f
design/nnls_pkg.sv
design/nnls_setup.sv
design/nnls_front.sv
design/nnls_queue.sv
design/nnls_back.sv
design/nearest_neighbor_letterbox_scaler.sv
sim/nearest_neighbor_letterbox_scaler_tb.sv
